// ----- rtl/cixd_pkg.sv -----
// Package: constants, status codes and signature table for the chunked image descrambler.
`default_nettype none
package cixd_pkg;

   localparam logic [31:0] TAG_END     = 32'h2046_4F45;
   localparam logic [31:0] TAG_PAGE    = 32'h4750_5043;
   localparam int          CHUNK_START = 69;
   localparam int          HEADER_LEN  = 10;
   localparam int          MASK_OFFSET = 16;
   localparam int          SIG_LEN     = 11;

   localparam int HC_W   = 7;
   localparam int OFF_W  = 33;
   localparam int TAG_W  = 32;
   localparam int BYTE_W = 8;

   typedef enum logic [2:0] {
      STATUS_SCAN    = 3'd0,
      STATUS_BAD_SIG = 3'd1,
      STATUS_BAD_VER = 3'd2,
      STATUS_END     = 3'd3,
      STATUS_NO_END  = 3'd4
   } status_type;

   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h54;
         4'd1:    val = 8'h33;
         4'd2:    val = 8'h2D;
         4'd3:    val = 8'h69;
         4'd4:    val = 8'h6D;
         4'd5:    val = 8'h61;
         4'd6:    val = 8'h67;
         4'd7:    val = 8'h65;
         4'd8:    val = 8'h0D;
         4'd9:    val = 8'h0A;
         4'd10:   val = 8'h1A;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cixd_step.sv -----
// Per-byte parse state and descramble logic, one byte per enabled cycle.
`default_nettype none
module cixd_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [cixd_pkg::BYTE_W-1:0]     data_in,
   input  wire logic                            last_in,
   output logic      [cixd_pkg::BYTE_W-1:0]     data_out,
   output cixd_pkg::status_type                 status
);

   localparam int HC_W  = cixd_pkg::HC_W;
   localparam int OFF_W = cixd_pkg::OFF_W;
   localparam int TAG_W = cixd_pkg::TAG_W;

   localparam logic [HC_W-1:0]  HC_START = HC_W'(cixd_pkg::CHUNK_START);
   localparam logic [HC_W-1:0]  HC_SIG   = HC_W'(cixd_pkg::SIG_LEN);
   localparam logic [HC_W-1:0]  HC_VERHI = HC_W'(cixd_pkg::SIG_LEN + 1);
   localparam logic [OFF_W-1:0] OFF_HLAST = OFF_W'(cixd_pkg::HEADER_LEN - 1);
   localparam logic [OFF_W-1:0] OFF_MASK  = OFF_W'(cixd_pkg::MASK_OFFSET);
   localparam logic [OFF_W-1:0] OFF_HLEN  = OFF_W'(cixd_pkg::HEADER_LEN);

   logic [HC_W-1:0]       header_count_ff, header_count_in;
   logic [7:0]            version_low_ff, version_low_in;
   logic [OFF_W-1:0]      chunk_offset_ff, chunk_offset_in;
   logic [TAG_W-1:0]      chunk_tag_ff, chunk_tag_in;
   logic [OFF_W-1:0]      chunk_size_ff, chunk_size_in;
   logic [7:0]            xor_mask_ff, xor_mask_in;
   cixd_pkg::status_type  outcome_ff, outcome_in;

   logic [OFF_W-1:0]      off_next;
   logic                  page_hit;

   always_comb begin
      header_count_in = header_count_ff;
      version_low_in  = version_low_ff;
      chunk_offset_in = chunk_offset_ff;
      chunk_tag_in    = chunk_tag_ff;
      chunk_size_in   = chunk_size_ff;
      xor_mask_in     = xor_mask_ff;
      outcome_in      = outcome_ff;
      data_out        = data_in;
      off_next        = chunk_offset_ff + OFF_W'(1);
      page_hit        = 1'b0;

      if (outcome_ff == cixd_pkg::STATUS_SCAN) begin
         if (header_count_ff < HC_START) begin
            if (header_count_ff < HC_SIG) begin
               if (data_in != cixd_pkg::sig_byte(header_count_ff[3:0]) || last_in) begin
                  outcome_in = cixd_pkg::STATUS_BAD_SIG;
               end
            end else if (header_count_ff == HC_SIG) begin
               version_low_in = data_in;
               if (last_in) begin
                  outcome_in = (data_in == 8'd1) ? cixd_pkg::STATUS_NO_END
                                                 : cixd_pkg::STATUS_BAD_VER;
               end
            end else if (header_count_ff == HC_VERHI) begin
               if (!(version_low_ff == 8'd1 && data_in == 8'd0)) begin
                  outcome_in = cixd_pkg::STATUS_BAD_VER;
               end
            end
            header_count_in = header_count_ff + HC_W'(1);
         end else begin
            if (chunk_offset_ff == '0) begin
               chunk_tag_in  = {24'd0, data_in};
               chunk_size_in = '0;
            end else if (chunk_offset_ff < OFF_W'(4)) begin
               case (chunk_offset_ff[1:0])
                  2'd1:    chunk_tag_in[15:8]  = data_in;
                  2'd2:    chunk_tag_in[23:16] = data_in;
                  2'd3:    chunk_tag_in[31:24] = data_in;
                  default: chunk_tag_in        = chunk_tag_ff;
               endcase
            end else if (chunk_offset_ff < OFF_W'(8)) begin
               case (chunk_offset_ff[1:0])
                  2'd0:    chunk_size_in[7:0]   = data_in;
                  2'd1:    chunk_size_in[15:8]  = data_in;
                  2'd2:    chunk_size_in[23:16] = data_in;
                  default: chunk_size_in = {1'b0, data_in, chunk_size_ff[23:0]} + OFF_HLEN;
               endcase
            end

            if (chunk_offset_ff == OFF_HLAST && chunk_tag_in == cixd_pkg::TAG_END) begin
               outcome_in = cixd_pkg::STATUS_END;
            end else begin
               page_hit = chunk_tag_in == cixd_pkg::TAG_PAGE &&
                          chunk_offset_ff >= OFF_MASK && chunk_offset_ff < chunk_size_in;
               if (page_hit) begin
                  if (chunk_offset_ff == OFF_MASK) begin
                     xor_mask_in = data_in;
                     data_out    = 8'd0;
                  end else begin
                     data_out = data_in ^ xor_mask_ff;
                  end
               end
               if (chunk_offset_ff >= OFF_HLAST && off_next >= chunk_size_in) begin
                  chunk_offset_in = '0;
               end else begin
                  chunk_offset_in = off_next;
               end
            end
         end
         if (last_in && outcome_in == cixd_pkg::STATUS_SCAN) begin
            outcome_in = cixd_pkg::STATUS_NO_END;
         end
      end
      status = outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_in)) begin
         header_count_ff <= '0;
         version_low_ff  <= '0;
         chunk_offset_ff <= '0;
         chunk_tag_ff    <= '0;
         chunk_size_ff   <= '0;
         xor_mask_ff     <= '0;
         outcome_ff      <= cixd_pkg::STATUS_SCAN;
      end else if (step) begin
         header_count_ff <= header_count_in;
         version_low_ff  <= version_low_in;
         chunk_offset_ff <= chunk_offset_in;
         chunk_tag_ff    <= chunk_tag_in;
         chunk_size_ff   <= chunk_size_in;
         xor_mask_ff     <= xor_mask_in;
         outcome_ff      <= outcome_in;
      end
   end

   a_hc_bound: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HC_START)
      else $error("header count past chunk start");

   a_done_pass: assert property (@(posedge clock) disable iff (reset)
      step && outcome_ff != cixd_pkg::STATUS_SCAN |-> data_out == data_in)
      else $error("byte altered after processing stopped");

   a_outcome_hold: assert property (@(posedge clock) disable iff (reset)
      step && !last_in && outcome_ff != cixd_pkg::STATUS_SCAN |=> $stable(outcome_ff))
      else $error("final outcome changed before end of file");

endmodule
`default_nettype wire

// ----- rtl/chunked_image_xor_descrambler_unit.sv -----
// Top level: input register, descramble step and result register with valid/stall handshake.
// An accepted byte goes from the input register through the step to the result register.
// Throughput: one byte per cycle absent rsp_stall; cixd_step state advances once per byte.
// A full result register that is stalled holds the input register, then stalls req.
// Reset (synchronous, active high) empties both registers and clears all parse state.
// The last byte of a file returns the parse state to reset for the next file.
`default_nettype none
module chunked_image_xor_descrambler_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [cixd_pkg::BYTE_W-1:0]  req_data_in,
   input  wire logic                         req_last_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [cixd_pkg::BYTE_W-1:0]  rsp_data_out,
   output logic                              rsp_last_out,
   output logic      [2:0]                   rsp_status
);

   logic                           in_valid_ff;
   logic [cixd_pkg::BYTE_W-1:0]    in_data_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff;
   logic [cixd_pkg::BYTE_W-1:0]    out_data_ff;
   logic                           out_last_ff;
   cixd_pkg::status_type           out_status_ff;

   logic                           out_free;
   logic                           advance;
   logic                           req_take;
   logic [cixd_pkg::BYTE_W-1:0]    step_data;
   cixd_pkg::status_type           step_status;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   cixd_step u_step (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .data_in  (in_data_ff),
      .last_in  (in_last_ff),
      .data_out (step_data),
      .status   (step_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_in;
         in_last_ff <= req_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff   <= step_data;
         out_last_ff   <= in_last_ff;
         out_status_ff <= step_status;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;
   assign rsp_last_out = out_last_ff;
   assign rsp_status   = out_status_ff;

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped byte did not reach result register");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_status_ff != cixd_pkg::STATUS_SCAN)
      else $error("last byte reported still scanning");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> rsp_status <= 3'(cixd_pkg::STATUS_NO_END))
      else $error("status code out of range");

endmodule
`default_nettype wire
